// ----- rtl/iptp_pkg.sv -----
// ----------------------------------------------------------------------------
// iptp_pkg
// Types, codes and character constants shared by the IPv4 range text parser.
// ----------------------------------------------------------------------------
package iptp_pkg;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [8:0] OCTET_MAX    = 9'd255;
    localparam logic [8:0] OCTET_SAT    = 9'd256;
    localparam logic [5:0] PREFIX_MAX   = 6'd32;
    localparam logic [5:0] PREFIX_SAT   = 6'd33;
    localparam logic [1:0] LAST_OCTET   = 2'd3;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_CIDR   = 2'd1,
        KIND_DASH   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic        parse_ok;
        logic [1:0]  range_kind;
        logic [31:0] range_begin;
        logic [31:0] range_end;
        logic [5:0]  prefix_length;
    } out_word_t;

    // Running parser state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [8:0]  octet_value;
        logic [1:0]  octet_count;
        logic        digit_seen;
        logic        space_after_digit;
        logic [23:0] address_accum;
        logic [31:0] first_address;
        logic [5:0]  prefix_value;
        logic        error_seen;
        kind_t       form_kind;
    } parse_state_t;

    function automatic parse_state_t reset_state();
        parse_state_t s;
        s                   = '0;
        s.phase             = PH_FIRST;
        s.form_kind         = KIND_SINGLE;
        return s;
    endfunction

endpackage

// ----- rtl/iptp_byte_step.sv -----
// ----------------------------------------------------------------------------
// iptp_byte_step
// Applies one text byte to the parser state: digit accumulation with
// saturation, whitespace tracking, dot and delimiter handling.
// ----------------------------------------------------------------------------
module iptp_byte_step (
    input  iptp_pkg::parse_state_t cur,
    input  logic [7:0]             text_byte,
    input  logic                   byte_present,
    output iptp_pkg::parse_state_t nxt
);

    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] octet_prod;
    logic [8:0]  prefix_prod;
    logic [31:0] closed_address;
    logic        close_bad;

    assign is_space = (text_byte == iptp_pkg::CH_SPACE) ||
                      ((text_byte >= iptp_pkg::CH_TAB) && (text_byte <= iptp_pkg::CH_CR));
    assign is_digit = (text_byte >= iptp_pkg::CH_ZERO) && (text_byte <= iptp_pkg::CH_NINE);
    // ASCII digits carry their value in the low nibble.
    assign digit    = text_byte[3:0];

    assign octet_prod  = {3'b000, cur.octet_value} * 12'd10 + {8'h00, digit};
    assign prefix_prod = {3'b000, cur.prefix_value} * 9'd10 + {5'b00000, digit};

    assign closed_address = {cur.address_accum, cur.octet_value[7:0]};
    assign close_bad      = !cur.digit_seen || (cur.octet_count != iptp_pkg::LAST_OCTET);

    always_comb
    begin
        nxt = cur;
        if (byte_present)
        begin
            if (is_space)
            begin
                if (cur.digit_seen)
                begin
                    nxt.space_after_digit = 1'b1;
                end
            end
            else if (is_digit)
            begin
                if (cur.space_after_digit)
                begin
                    nxt.error_seen = 1'b1;
                end
                nxt.digit_seen = 1'b1;
                if (cur.phase == iptp_pkg::PH_PREFIX)
                begin
                    if ((cur.prefix_value > iptp_pkg::PREFIX_MAX) ||
                        (prefix_prod > {3'b000, iptp_pkg::PREFIX_MAX}))
                    begin
                        nxt.error_seen   = 1'b1;
                        nxt.prefix_value = iptp_pkg::PREFIX_SAT;
                    end
                    else
                    begin
                        nxt.prefix_value = prefix_prod[5:0];
                    end
                end
                else
                begin
                    if ((cur.octet_value > iptp_pkg::OCTET_MAX) ||
                        (octet_prod > {3'b000, iptp_pkg::OCTET_MAX}))
                    begin
                        nxt.error_seen  = 1'b1;
                        nxt.octet_value = iptp_pkg::OCTET_SAT;
                    end
                    else
                    begin
                        nxt.octet_value = octet_prod[8:0];
                    end
                end
            end
            else if (text_byte == iptp_pkg::CH_DOT)
            begin
                if ((cur.phase == iptp_pkg::PH_PREFIX) || !cur.digit_seen ||
                    (cur.octet_count == iptp_pkg::LAST_OCTET))
                begin
                    nxt.error_seen = 1'b1;
                end
                else
                begin
                    nxt.address_accum = {cur.address_accum[15:0], cur.octet_value[7:0]};
                    nxt.octet_count   = cur.octet_count + 2'd1;
                end
                nxt.octet_value       = '0;
                nxt.digit_seen        = 1'b0;
                nxt.space_after_digit = 1'b0;
            end
            else if ((text_byte == iptp_pkg::CH_SLASH) || (text_byte == iptp_pkg::CH_DASH))
            begin
                if (cur.phase != iptp_pkg::PH_FIRST)
                begin
                    nxt.error_seen = 1'b1;
                end
                else
                begin
                    nxt.first_address     = closed_address;
                    nxt.error_seen        = cur.error_seen || close_bad;
                    nxt.address_accum     = '0;
                    nxt.octet_count       = '0;
                    nxt.octet_value       = '0;
                    nxt.digit_seen        = 1'b0;
                    nxt.space_after_digit = 1'b0;
                    if (text_byte == iptp_pkg::CH_SLASH)
                    begin
                        nxt.phase     = iptp_pkg::PH_PREFIX;
                        nxt.form_kind = iptp_pkg::KIND_CIDR;
                    end
                    else
                    begin
                        nxt.phase     = iptp_pkg::PH_SECOND;
                        nxt.form_kind = iptp_pkg::KIND_DASH;
                    end
                end
            end
            else
            begin
                nxt.error_seen = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/iptp_finish.sv -----
// ----------------------------------------------------------------------------
// iptp_finish
// Builds the result word at end of text: closes the last address, applies
// the prefix mask or orders the dash range, and zeroes a failed result.
// ----------------------------------------------------------------------------
module iptp_finish (
    input  iptp_pkg::parse_state_t st,
    output iptp_pkg::out_word_t    result
);

    logic [31:0] closed_address;
    logic        close_bad;
    logic [5:0]  plen;
    logic [31:0] mask;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [5:0]  plen_out;
    logic        bad;

    assign closed_address = {st.address_accum, st.octet_value[7:0]};
    assign close_bad      = !st.digit_seen || (st.octet_count != iptp_pkg::LAST_OCTET);
    assign plen = (st.prefix_value > iptp_pkg::PREFIX_MAX) ? iptp_pkg::PREFIX_MAX
                                                           : st.prefix_value;
    // A shift by the full width clears the word, so a /32 gives an all-ones mask.
    assign mask = ~(32'hFFFF_FFFF >> plen);

    always_comb
    begin
        lo       = closed_address;
        hi       = closed_address;
        plen_out = '0;
        bad      = st.error_seen;
        case (st.phase)
            iptp_pkg::PH_FIRST:
            begin
                bad = st.error_seen || close_bad;
            end
            iptp_pkg::PH_PREFIX:
            begin
                bad      = st.error_seen || !st.digit_seen ||
                           (st.prefix_value > iptp_pkg::PREFIX_MAX);
                plen_out = plen;
                lo       = st.first_address & mask;
                hi       = (st.first_address & mask) | ~mask;
            end
            default:
            begin
                bad = st.error_seen || close_bad;
                if (st.first_address < closed_address)
                begin
                    lo = st.first_address;
                    hi = closed_address;
                end
                else
                begin
                    lo = closed_address;
                    hi = st.first_address;
                end
            end
        endcase

        if (bad)
        begin
            result = '0;
        end
        else
        begin
            result.parse_ok      = 1'b1;
            result.range_kind    = st.form_kind;
            result.range_begin   = lo;
            result.range_end     = hi;
            result.prefix_length = plen_out;
        end
    end

endmodule

// ----- rtl/ipv4_range_text_parser_unit.sv -----
// Result path: an end_of_text word moves from the input register to the result
// register once that is free. Throughput: one text byte per cycle except while an
// ending word waits for the result register; the per-byte state update is one
// multiply-by-ten-add and a compare on the octet or prefix register.
// A waiting result does not stop bytes that end no text from flowing.
// Reset (rst_n low, asynchronous) empties both stages and clears the parser state.
// ----------------------------------------------------------------------------
// ipv4_range_text_parser_unit
// Input register, parser state register and result register around the
// byte step and finish logic.
// ----------------------------------------------------------------------------
module ipv4_range_text_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iptp_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output iptp_pkg::out_word_t out_word
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    iptp_pkg::in_word_t     s1_word_reg;
    iptp_pkg::parse_state_t state_reg;
    iptp_pkg::parse_state_t state_next;
    iptp_pkg::parse_state_t stepped;
    iptp_pkg::out_word_t    result;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    iptp_pkg::out_word_t    out_word_reg;
    logic                   out_free;
    logic                   s1_go;
    logic                   s1_emit;

    iptp_byte_step u_step (
        .cur          (state_reg),
        .text_byte    (s1_word_reg.text_byte),
        .byte_present (s1_word_reg.byte_present),
        .nxt          (stepped)
    );

    iptp_finish u_finish (
        .st     (stepped),
        .result (result)
    );

    // Only a word that ends a text needs room in the result register.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (!s1_word_reg.end_of_text || out_free);
    assign s1_emit  = s1_go && s1_word_reg.end_of_text;
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (s1_go)
        begin
            state_next = s1_word_reg.end_of_text ? iptp_pkg::reset_state() : stepped;
        end
        if (s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= iptp_pkg::reset_state();
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_emit)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The input stalls only behind an ending word that waits for the result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_word_reg.end_of_text && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked end of text");

    // Every end of text leaves the parser in its reset state.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit |=> (state_reg == iptp_pkg::reset_state()))
        else $error("parser state not cleared after end of text");

    // A failed result carries nothing but zeros.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.parse_ok) |->
            (out_word.range_kind == iptp_pkg::KIND_SINGLE && out_word.range_begin == 32'h0 &&
             out_word.range_end == 32'h0 && out_word.prefix_length == 6'd0))
        else $error("failed result is not all zero");

    // A good range is ordered, and only CIDR reports a prefix.
    a_ok_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.parse_ok) |->
            (out_word.range_begin <= out_word.range_end &&
             out_word.prefix_length <= iptp_pkg::PREFIX_MAX &&
             (out_word.range_kind == iptp_pkg::KIND_CIDR || out_word.prefix_length == 6'd0)))
        else $error("inconsistent successful result");

endmodule
